/* rtl/great_circle_angle_azel_macros.svh */
// Assertion macros for the great circle angle block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef GREAT_CIRCLE_ANGLE_AZEL_MACROS_SVH
`define GREAT_CIRCLE_ANGLE_AZEL_MACROS_SVH

`define GCA_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define GCA_AFTER(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

/* rtl/gca_pkg.sv */
// Shared types, constants and the arctangent table for the great circle angle block.
// No dependencies.
package gca_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	localparam int SQRT_STEPS = 31;
	localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	localparam logic [31:0] ATAN_TURN [0:TABLE_LEN-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [ANGLE_BITS-1:0] target_azimuth;
		logic signed [ANGLE_BITS-1:0] target_elevation;
		logic [ANGLE_BITS-1:0] axis_azimuth;
		logic signed [ANGLE_BITS-1:0] axis_elevation;
	} in_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] central_angle;
		logic signed [15:0] cosine_value;
	} out_t;
endpackage

/* rtl/gca_sincos.sv */
// Pipelined rotation-mode CORDIC giving sine and cosine in Q1.15.
// Depends on gca_pkg for the arctangent table and the start gain.
module gca_sincos #(
	parameter int STEPS = gca_pkg::CORDIC_STEPS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req,
	input  logic [31:0] angle,
	output logic ack,
	output logic signed [16:0] cos_val,
	output logic signed [16:0] sin_val
);
	logic vld_s [0:STEPS];
	logic neg_s [0:STEPS];
	logic signed [32:0] x_s [0:STEPS];
	logic signed [32:0] y_s [0:STEPS];
	logic signed [33:0] z_s [0:STEPS];
	logic fold;
	logic [31:0] folded;
	logic signed [32:0] xf, yf;
	logic signed [33:0] xr, yr;
	logic signed [18:0] xs, ys;
	logic ack_q;
	logic signed [16:0] cos_q, sin_q;

	assign fold = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
	assign folded = {angle[31] ^ fold, angle[30:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= req;
		end
	end

	always_ff @(posedge clk) begin
		neg_s[0] <= fold;
		x_s[0] <= gca_pkg::INV_GAIN_Q30;
		y_s[0] <= '0;
		z_s[0] <= signed'({{2{folded[31]}}, folded});
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [32:0] dx, dy;
		logic signed [33:0] at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = signed'({2'b00, gca_pkg::ATAN_TURN[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - at;
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + at;
			end
		end
	end

	assign xf = neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign yf = neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	assign xr = (34'(xf) + 34'sd16384) >>> 15;
	assign yr = (34'(yf) + 34'sd16384) >>> 15;
	assign xs = xr[18:0];
	assign ys = yr[18:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_q <= 1'b0;
		end else begin
			ack_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (xs > 19'sd32768) cos_q <= 17'sd32768;
		else if (xs < -19'sd32768) cos_q <= -17'sd32768;
		else cos_q <= xs[16:0];
		if (ys > 19'sd32768) sin_q <= 17'sd32768;
		else if (ys < -19'sd32768) sin_q <= -17'sd32768;
		else sin_q <= ys[16:0];
	end

	assign ack = ack_q;
	assign cos_val = cos_q;
	assign sin_val = sin_q;
endmodule

/* rtl/gca_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with side data carried along.
// Depends on gca_pkg for the stage count.
module gca_isqrt #(
	parameter int SIDE_W = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req,
	input  logic [60:0] radicand,
	input  logic [SIDE_W-1:0] side,
	output logic ack,
	output logic [30:0] root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int N = gca_pkg::SQRT_STEPS;

	logic vld_s [0:N];
	logic [61:0] v_s [0:N];
	logic [61:0] r_s [0:N];
	logic [SIDE_W-1:0] side_s [0:N];

	assign vld_s[0] = req;
	assign v_s[0] = {1'b0, radicand};
	assign r_s[0] = '0;
	assign side_s[0] = side;

	for (genvar k = 0; k < N; k++) begin : g_bit
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
		logic [61:0] trial;
		assign trial = r_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			if (v_s[k] >= trial) begin
				v_s[k+1] <= v_s[k] - trial;
				r_s[k+1] <= (r_s[k] >> 1) + BIT;
			end else begin
				v_s[k+1] <= v_s[k];
				r_s[k+1] <= r_s[k] >> 1;
			end
		end
	end

	assign ack = vld_s[N];
	assign root = r_s[N][30:0];
	assign side_out = side_s[N];
endmodule

/* rtl/gca_atan.sv */
// Pipelined vectoring-mode CORDIC giving the arccosine angle in 32-bit turns.
// Depends on gca_pkg for the arctangent table.
module gca_atan #(
	parameter int STEPS = gca_pkg::CORDIC_STEPS,
	parameter int SIDE_W = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req,
	input  logic signed [31:0] cosine,
	input  logic [30:0] sine,
	input  logic [SIDE_W-1:0] side,
	output logic ack,
	output logic signed [33:0] angle,
	output logic [SIDE_W-1:0] side_out
);
	logic vld_s [0:STEPS];
	logic signed [32:0] x_s [0:STEPS];
	logic signed [32:0] y_s [0:STEPS];
	logic signed [33:0] z_s [0:STEPS];
	logic [SIDE_W-1:0] side_s [0:STEPS];
	logic signed [32:0] dw, sw;

	assign dw = 33'(cosine);
	assign sw = signed'({2'b00, sine});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= req;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side;
		if (cosine[31]) begin
			x_s[0] <= sw;
			y_s[0] <= -dw;
			z_s[0] <= gca_pkg::QUARTER_TURN;
		end else begin
			x_s[0] <= dw;
			y_s[0] <= sw;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic signed [32:0] dx, dy;
		logic signed [33:0] at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = signed'({2'b00, gca_pkg::ATAN_TURN[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (y_s[i] > 33'sd0) begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + at;
			end else begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - at;
			end
		end
	end

	assign ack = vld_s[STEPS];
	assign angle = z_s[STEPS];
	assign side_out = side_s[STEPS];
endmodule

/* rtl/great_circle_angle_azel.sv */
// Top level of the great circle angle block: unit vectors, dot product, arccosine.
// Depends on gca_pkg, gca_sincos, gca_isqrt, gca_atan and the assertion macro header.
//
// Usage: drive cmd with two directions (target and reference axis, azimuth and
// elevation as binary angles) and raise start for one cycle per transaction.
// busy is always low, so a new transaction may be started in every cycle.
// Each transaction yields one result: done is high for exactly one cycle while
// result holds the central angle (32768 is half a turn) and the clamped cosine
// in Q1.14. The receiver cannot stall and must take the result in that cycle.
// From start to done a transaction passes through the sine and cosine pipelines,
// the registered multiply, sum, clamp and square steps, the 31 stages of the
// bit-per-stage square root, the arctangent pipeline and one output register.
// Throughput is one transaction per cycle, results in the order of starts.
// Asynchronous reset clears all valid bits; transactions in flight are dropped.
`include "great_circle_angle_azel_macros.svh"

module great_circle_angle_azel #(
	parameter int CORDIC_STEPS = gca_pkg::CORDIC_STEPS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  gca_pkg::in_t cmd,
	output logic done,
	output gca_pkg::out_t result
);
	localparam int PAD = 32 - gca_pkg::ANGLE_BITS;
	localparam int LATENCY = 2 * CORDIC_STEPS + 40;

	logic [31:0] ta32, te32, ra32, re32;
	logic v_ta, v_te, v_ra, v_re;
	logic signed [16:0] tca, tsa, tce, tse, rca, rsa, rce, rse;

	assign busy = 1'b0;
	assign ta32 = {cmd.target_azimuth, {PAD{1'b0}}};
	assign te32 = {cmd.target_elevation, {PAD{1'b0}}};
	assign ra32 = {cmd.axis_azimuth, {PAD{1'b0}}};
	assign re32 = {cmd.axis_elevation, {PAD{1'b0}}};

	gca_sincos #(.STEPS(CORDIC_STEPS)) u_ta (.clk, .arst_n, .req(start), .angle(ta32),
		.ack(v_ta), .cos_val(tca), .sin_val(tsa));
	gca_sincos #(.STEPS(CORDIC_STEPS)) u_te (.clk, .arst_n, .req(start), .angle(te32),
		.ack(v_te), .cos_val(tce), .sin_val(tse));
	gca_sincos #(.STEPS(CORDIC_STEPS)) u_ra (.clk, .arst_n, .req(start), .angle(ra32),
		.ack(v_ra), .cos_val(rca), .sin_val(rsa));
	gca_sincos #(.STEPS(CORDIC_STEPS)) u_re (.clk, .arst_n, .req(start), .angle(re32),
		.ack(v_re), .cos_val(rce), .sin_val(rse));

	logic signed [33:0] ptx, pty, prx, pry;
	logic signed [33:0] rtx, rty, rrx, rry;
	assign ptx = tce * tca;
	assign pty = tce * tsa;
	assign prx = rce * rca;
	assign pry = rce * rsa;
	assign rtx = (ptx + 34'sd16384) >>> 15;
	assign rty = (pty + 34'sd16384) >>> 15;
	assign rrx = (prx + 34'sd16384) >>> 15;
	assign rry = (pry + 34'sd16384) >>> 15;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [16:0] tx_s1, ty_s1, tz_s1, rx_s1, ry_s1, rz_s1;
	logic signed [33:0] px_s2, py_s2, pz_s2;
	logic signed [31:0] d_s3, d_s4, d_s5;
	logic signed [15:0] co_s3, co_s4, co_s5;
	logic [63:0] sq_s4;
	logic [60:0] rem_s5;
	logic signed [35:0] dsum;
	logic signed [31:0] dclamp;
	logic signed [32:0] coround;

	assign dsum = 36'(px_s2) + 36'(py_s2) + 36'(pz_s2);
	always_comb begin
		if (dsum > 36'(gca_pkg::ONE_Q30)) dclamp = gca_pkg::ONE_Q30;
		else if (dsum < -36'(gca_pkg::ONE_Q30)) dclamp = -gca_pkg::ONE_Q30;
		else dclamp = dsum[31:0];
	end
	assign coround = (33'(dclamp) + 33'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= v_ta & v_te & v_ra & v_re;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tx_s1 <= rtx[16:0];
		ty_s1 <= rty[16:0];
		tz_s1 <= tse;
		rx_s1 <= rrx[16:0];
		ry_s1 <= rry[16:0];
		rz_s1 <= rse;
		px_s2 <= tx_s1 * rx_s1;
		py_s2 <= ty_s1 * ry_s1;
		pz_s2 <= tz_s1 * rz_s1;
		d_s3 <= dclamp;
		co_s3 <= coround[15:0];
		sq_s4 <= 64'(d_s3 * d_s3);
		d_s4 <= d_s3;
		co_s4 <= co_s3;
		rem_s5 <= 61'((64'd1 << 60) - sq_s4);
		d_s5 <= d_s4;
		co_s5 <= co_s4;
	end

	logic v_sq;
	logic [30:0] root;
	logic [47:0] side_sq;

	gca_isqrt #(.SIDE_W(48)) u_isqrt (.clk, .arst_n, .req(vld_s5), .radicand(rem_s5),
		.side({d_s5, co_s5}), .ack(v_sq), .root(root), .side_out(side_sq));

	logic v_at;
	logic signed [33:0] zang;
	logic [15:0] co_at;

	gca_atan #(.STEPS(CORDIC_STEPS), .SIDE_W(16)) u_atan (.clk, .arst_n, .req(v_sq),
		.cosine(side_sq[47:16]), .sine(root), .side(side_sq[15:0]), .ack(v_at),
		.angle(zang), .side_out(co_at));

	localparam logic signed [34:0] HALF = 35'sd1 << (gca_pkg::ANGLE_BITS - 1);
	localparam logic signed [34:0] RND = 35'sd1 << (PAD - 1);

	logic signed [34:0] ang;
	logic done_q;
	gca_pkg::out_t result_q;

	assign ang = (35'(zang) + RND) >>> PAD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_at;
		end
	end

	always_ff @(posedge clk) begin
		if (ang < 35'sd0) result_q.central_angle <= '0;
		else if (ang > HALF) result_q.central_angle <= HALF[gca_pkg::ANGLE_BITS-1:0];
		else result_q.central_angle <= ang[gca_pkg::ANGLE_BITS-1:0];
		result_q.cosine_value <= co_at;
	end

	assign done = done_q;
	assign result = result_q;

	`GCA_AFTER(a_latency, start, LATENCY, done, "result strobe missing after fixed latency")
	`GCA_CHECK(a_angle_range, done, result.central_angle <= 16'd32768, "angle beyond half turn")
	`GCA_CHECK(a_cos_range, done,
		(result.cosine_value <= 16'sd16384) && (result.cosine_value >= -16'sd16384),
		"cosine outside clamp range")
endmodule
